>>> rtl/core/msp_pkg.sv
package msp_pkg;

   localparam int NUM_STACKS  = 4;
   localparam int NUM_SLOTS   = 64;
   localparam int STACK_W     = 2;
   localparam int VALUE_W     = 32;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int COUNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int REGION_W    = $clog2(NUM_STACKS + 1);
   localparam int FREE_REGION = NUM_STACKS;
   localparam int LIST_DEPTH  = (NUM_STACKS + 1) * NUM_SLOTS;
   localparam int LIST_AW     = $clog2(LIST_DEPTH);

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
   } data_ram_cmd_type;

   typedef struct packed {
      logic               wr_en;
      logic [LIST_AW-1:0] wr_addr;
      logic [SLOT_W-1:0]  wr_data;
      logic               rd_en;
      logic [LIST_AW-1:0] rd_addr;
   } list_ram_cmd_type;

   typedef struct packed {
      logic valid;
      logic accepted;
      logic was_empty;
      logic from_memory;
   } result_type;

   // Each stack and the free list own a region of NUM_SLOTS entries in the list memory.
   function automatic logic [LIST_AW-1:0] list_addr(input logic [REGION_W-1:0] region,
                                                    input logic [COUNT_W-1:0]  pos);
      return LIST_AW'(region) * LIST_AW'(NUM_SLOTS) + LIST_AW'(pos);
   endfunction

endpackage

>>> rtl/core/msp_ram.sv
module msp_ram
   #(parameter int DEPTH = 64,
     parameter int WIDTH = 32,
     localparam int AW = $clog2(DEPTH))
   (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/msp_ctrl.sv
module msp_ctrl
   import msp_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   input  logic [STACK_W-1:0]  req_stack_number,
   input  logic [VALUE_W-1:0]  req_push_value,
   output logic                busy,
   input  logic                result_ready,
   input  logic [SLOT_W-1:0]   list_rd_data,
   output data_ram_cmd_type    data_cmd,
   output list_ram_cmd_type    list_cmd,
   output result_type          result
   );

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_PUSH_SLOT = 4'b0010,
      ST_POP_LIST  = 4'b0100,
      ST_FINISH    = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] depth_ff [NUM_STACKS];
   logic [COUNT_W-1:0] depth_in [NUM_STACKS];
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [COUNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [LIST_AW-1:0] list_pos_ff, list_pos_in;
   logic               accepted_ff, accepted_in;
   logic               empty_ff, empty_in;
   logic               from_mem_ff, from_mem_in;
   logic               stack_ok;
   logic [COUNT_W-1:0] cur_depth;

   assign stack_ok  = (int'(req_stack_number) < NUM_STACKS);
   assign cur_depth = depth_ff[req_stack_number];

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      used_in     = used_ff;
      free_cnt_in = free_cnt_ff;
      fresh_in    = fresh_ff;
      value_in    = value_ff;
      list_pos_in = list_pos_ff;
      accepted_in = accepted_ff;
      empty_in    = empty_ff;
      from_mem_in = from_mem_ff;
      data_cmd    = '0;
      list_cmd    = '0;
      result      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in    = req_push_value;
               accepted_in = 1'b0;
               empty_in    = 1'b0;
               from_mem_in = 1'b0;
               state_in    = ST_FINISH;
               if (req_kind == KIND_PUSH) begin
                  if (stack_ok && used_ff < COUNT_W'(NUM_SLOTS)
                      && cur_depth < COUNT_W'(NUM_SLOTS)) begin
                     accepted_in                = 1'b1;
                     used_in                    = used_ff + 1'b1;
                     depth_in[req_stack_number] = cur_depth + 1'b1;
                     list_pos_in = list_addr(REGION_W'(req_stack_number), cur_depth);
                     if (free_cnt_ff != '0) begin
                        // Reuse the most recently freed slot.
                        list_cmd.rd_en   = 1'b1;
                        list_cmd.rd_addr = list_addr(REGION_W'(FREE_REGION),
                                                     free_cnt_ff - 1'b1);
                        free_cnt_in      = free_cnt_ff - 1'b1;
                        state_in         = ST_PUSH_SLOT;
                     end else begin
                        // The free list is empty, so take the next untouched one.
                        data_cmd.wr_en   = 1'b1;
                        data_cmd.wr_addr = fresh_ff[SLOT_W-1:0];
                        data_cmd.wr_data = req_push_value;
                        list_cmd.wr_en   = 1'b1;
                        list_cmd.wr_addr = list_addr(REGION_W'(req_stack_number),
                                                     cur_depth);
                        list_cmd.wr_data = fresh_ff[SLOT_W-1:0];
                        fresh_in         = fresh_ff + 1'b1;
                     end
                  end
               end else begin
                  if (stack_ok && cur_depth != '0) begin
                     list_cmd.rd_en   = 1'b1;
                     list_cmd.rd_addr = list_addr(REGION_W'(req_stack_number),
                                                  cur_depth - 1'b1);
                     depth_in[req_stack_number] = cur_depth - 1'b1;
                     used_in     = used_ff - 1'b1;
                     from_mem_in = 1'b1;
                     state_in    = ST_POP_LIST;
                  end else begin
                     empty_in = 1'b1;
                  end
               end
            end
         end
         ST_PUSH_SLOT: begin
            data_cmd.wr_en   = 1'b1;
            data_cmd.wr_addr = list_rd_data;
            data_cmd.wr_data = value_ff;
            list_cmd.wr_en   = 1'b1;
            list_cmd.wr_addr = list_pos_ff;
            list_cmd.wr_data = list_rd_data;
            state_in         = ST_FINISH;
         end
         ST_POP_LIST: begin
            data_cmd.rd_en   = 1'b1;
            data_cmd.rd_addr = list_rd_data;
            list_cmd.wr_en   = 1'b1;
            list_cmd.wr_addr = list_addr(REGION_W'(FREE_REGION), free_cnt_ff);
            list_cmd.wr_data = list_rd_data;
            free_cnt_in      = free_cnt_ff + 1'b1;
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            if (result_ready) begin
               result.valid       = 1'b1;
               result.accepted    = accepted_ff;
               result.was_empty   = empty_ff;
               result.from_memory = from_mem_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         depth_ff    <= '{default: '0};
         used_ff     <= '0;
         free_cnt_ff <= '0;
         fresh_ff    <= '0;
         accepted_ff <= 1'b0;
         empty_ff    <= 1'b0;
         from_mem_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         used_ff     <= used_in;
         free_cnt_ff <= free_cnt_in;
         fresh_ff    <= fresh_in;
         accepted_ff <= accepted_in;
         empty_ff    <= empty_in;
         from_mem_ff <= from_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      list_pos_ff <= list_pos_in;
   end

endmodule

>>> rtl/core/multi_stack_shared_pool.sv
// Several LIFO stacks share one pool of data slots. Each request beat on the req_ channel
// is either a push of req_push_value onto stack req_stack_number or a pop from that stack.
// Every request beat yields exactly one response beat on the rsp_ channel, in order.
// A push answers rsp_accepted high when the value was stored and low when the pool is full.
// A pop answers with the newest value of the stack, or with rsp_was_empty high and a value
// of all ones when the stack holds nothing.
// One request is worked on at a time. A push that takes an untouched slot goes straight
// to the finish state; a push that reuses a freed slot first reads the slot list memory,
// and a pop reads the slot list memory and then the data memory before it finishes.
// The next request can be accepted in the same cycle in which the previous one appears
// in the response register; req_stall is high from acceptance until then. A response
// that the receiver stalls does not hold up the next request's memory work; only its
// completion waits until the response register is free.
// Reset empties every stack and the pool at once; no clearing pass is needed, and the
// memories themselves are not cleared.
module multi_stack_shared_pool
   import msp_pkg::*;
   (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [STACK_W-1:0]        req_stack_number,
   input  logic signed [VALUE_W-1:0] req_push_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_accepted,
   output logic                      rsp_was_empty,
   output logic signed [VALUE_W-1:0] rsp_popped_value
   );

   data_ram_cmd_type   data_cmd;
   list_ram_cmd_type   list_cmd;
   result_type         result;
   logic [VALUE_W-1:0] data_rd_data;
   logic [SLOT_W-1:0]  list_rd_data;
   logic               busy;
   logic               out_free;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_accepted_ff;
   logic                      rsp_was_empty_ff;
   logic signed [VALUE_W-1:0] rsp_popped_value_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   msp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_kind         (req_kind),
      .req_stack_number (req_stack_number),
      .req_push_value   (req_push_value),
      .busy             (busy),
      .result_ready     (out_free),
      .list_rd_data     (list_rd_data),
      .data_cmd         (data_cmd),
      .list_cmd         (list_cmd),
      .result           (result)
   );

   msp_ram #(.DEPTH(NUM_SLOTS), .WIDTH(VALUE_W)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_cmd.wr_en),
      .wr_addr (data_cmd.wr_addr),
      .wr_data (data_cmd.wr_data),
      .rd_en   (data_cmd.rd_en),
      .rd_addr (data_cmd.rd_addr),
      .rd_data (data_rd_data)
   );

   msp_ram #(.DEPTH(LIST_DEPTH), .WIDTH(SLOT_W)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_cmd.wr_en),
      .wr_addr (list_cmd.wr_addr),
      .wr_data (list_cmd.wr_data),
      .rd_en   (list_cmd.rd_en),
      .rd_addr (list_cmd.rd_addr),
      .rd_data (list_rd_data)
   );

   assign req_stall = busy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_accepted_ff     <= result.accepted;
         rsp_was_empty_ff    <= result.was_empty;
         rsp_popped_value_ff <= result.from_memory ? signed'(data_rd_data) : EMPTY_VALUE;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_was_empty    = rsp_was_empty_ff;
   assign rsp_popped_value = rsp_popped_value_ff;

endmodule
